>>> rtl/adf_pkg.sv
package adf_pkg;

    // Line control bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h10;

    // Field widths
    localparam int LEN_W  = 9;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Frame store size; the usable length limit is one below it
    localparam int BUFFER_BYTES = 512;
    localparam int LIMIT_CAP_I  =
        ((BUFFER_BYTES - 1) > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : (BUFFER_BYTES - 1);
    localparam logic [LEN_W-1:0] LIMIT_CAP = LIMIT_CAP_I[LEN_W-1:0];

    // Register reset values
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 9'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd511;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_FRAME_LEN = 8'd0,
        REG_MAX_FRAME_LEN = 8'd1
    } cfg_reg_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_DATA     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_PARITY   = 3'd2,
        EV_RUNT     = 3'd3,
        EV_ABORT    = 3'd4,
        EV_OVERSIZE = 3'd5
    } event_t;

    // One step of the deframer, frame side
    typedef struct packed {
        logic              has_result;
        event_t            ev;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  pos;
    } frame_res_t;

    // Error totals after a step
    typedef struct packed {
        logic [CNT_W-1:0] runt;
        logic [CNT_W-1:0] abort;
        logic [CNT_W-1:0] oversize;
        logic [CNT_W-1:0] parity;
    } totals_t;

endpackage

>>> rtl/adf_frame.sv
module adf_frame
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [adf_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [adf_pkg::LEN_W-1:0]    min_len,
    input  logic [adf_pkg::LEN_W-1:0]    max_len,
    output adf_pkg::frame_res_t          res
);

    logic                       esc_reg;
    logic                       esc_next;
    logic [adf_pkg::LEN_W-1:0]  len_reg;
    logic [adf_pkg::LEN_W-1:0]  len_next;
    logic [adf_pkg::BYTE_W-1:0] xor_reg;
    logic [adf_pkg::BYTE_W-1:0] xor_next;
    logic [adf_pkg::BYTE_W-1:0] ub;
    logic [adf_pkg::LEN_W-1:0]  limit;

    // Effective length limit, capped by the frame store
    assign limit = (max_len > adf_pkg::LIMIT_CAP) ? adf_pkg::LIMIT_CAP : max_len;

    // Unescaped byte
    assign ub = esc_reg ? (rx_byte ^ adf_pkg::ESC_XOR) : rx_byte;

    // Per-byte decision
    always_comb
    begin
        esc_next       = esc_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        res.has_result = 1'b0;
        res.ev         = adf_pkg::EV_DATA;
        res.data       = '0;
        res.pos        = len_reg;
        if (rx_byte == adf_pkg::FLAG_BYTE)
        begin
            esc_next = 1'b0;
            len_next = '0;
            xor_next = '0;
            res.has_result = 1'b1;
            if (esc_reg)
            begin
                res.ev = adf_pkg::EV_ABORT;
            end
            else if (len_reg == '0)
            begin
                res.has_result = 1'b0;
            end
            else if (len_reg < min_len)
            begin
                res.ev = adf_pkg::EV_RUNT;
            end
            else if (xor_reg != '0)
            begin
                res.ev = adf_pkg::EV_PARITY;
            end
            else
            begin
                res.ev = adf_pkg::EV_GOOD;
            end
        end
        else if (rx_byte == adf_pkg::ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else if (len_reg >= limit)
        begin
            // Oversize: byte dropped, frame restarts
            esc_next       = 1'b0;
            len_next       = '0;
            xor_next       = '0;
            res.has_result = 1'b1;
            res.ev         = adf_pkg::EV_OVERSIZE;
        end
        else
        begin
            esc_next       = 1'b0;
            len_next       = len_reg + 1'b1;
            xor_next       = xor_reg ^ ub;
            res.has_result = 1'b1;
            res.ev         = adf_pkg::EV_DATA;
            res.data       = ub;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            len_reg <= '0;
            xor_reg <= '0;
        end
        else if (step)
        begin
            esc_reg <= esc_next;
            len_reg <= len_next;
            xor_reg <= xor_next;
        end
    end

endmodule

>>> rtl/adf_err_cnt.sv
module adf_err_cnt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  adf_pkg::event_t  ev,
    output adf_pkg::totals_t totals_next
);

    adf_pkg::totals_t totals_reg;

    // Saturating increment of the counter matching the event
    always_comb
    begin
        totals_next = totals_reg;
        case (ev)
            adf_pkg::EV_RUNT:
                if (totals_reg.runt != adf_pkg::CNT_MAX)
                    totals_next.runt = totals_reg.runt + 1'b1;
            adf_pkg::EV_ABORT:
                if (totals_reg.abort != adf_pkg::CNT_MAX)
                    totals_next.abort = totals_reg.abort + 1'b1;
            adf_pkg::EV_OVERSIZE:
                if (totals_reg.oversize != adf_pkg::CNT_MAX)
                    totals_next.oversize = totals_reg.oversize + 1'b1;
            adf_pkg::EV_PARITY:
                if (totals_reg.parity != adf_pkg::CNT_MAX)
                    totals_next.parity = totals_reg.parity + 1'b1;
            default:
                totals_next = totals_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            totals_reg <= '0;
        end
        else if (step)
        begin
            totals_reg <= totals_next;
        end
    end

endmodule

>>> rtl/async_hdlc_deframer_parity_check.sv
// Pipeline: a byte's input transfer loads the input register; its result is then
// written to the result register, which drives the output until it is taken.
// Throughput: one line byte per cycle; the input register, step logic and result
// register run as a two-register pipeline that stalls only on a held result.
// Reset (rst_n, async, active low) empties the pipeline, clears frame state and
// error counters, and sets min_frame_len to 4 and max_frame_len to 511.
module async_hdlc_deframer_parity_check
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [adf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Line bytes in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    // Results out
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         event_res,
    output logic [7:0]                         data_byte,
    output logic [8:0]                         position,
    output logic [15:0]                        runt_total,
    output logic [15:0]                        abort_total,
    output logic [15:0]                        oversize_total,
    output logic [15:0]                        parity_fail_total
);

    logic [adf_pkg::LEN_W-1:0]  min_len_reg;
    logic [adf_pkg::LEN_W-1:0]  max_len_reg;
    logic                       in_valid_reg;
    logic [adf_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       out_valid_reg;
    logic                       step;
    adf_pkg::frame_res_t        fres;
    adf_pkg::totals_t           totals_next;
    adf_pkg::frame_res_t        res_reg;
    adf_pkg::totals_t           tot_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= adf_pkg::MIN_LEN_RESET;
            max_len_reg <= adf_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == adf_pkg::REG_MIN_FRAME_LEN)
                min_len_reg <= cfg_data[adf_pkg::LEN_W-1:0];
            else if (cfg_index == adf_pkg::REG_MAX_FRAME_LEN)
                max_len_reg <= cfg_data[adf_pkg::LEN_W-1:0];
        end
    end

    // Pipeline control
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    adf_frame u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .min_len (min_len_reg),
        .max_len (max_len_reg),
        .res     (fres)
    );

    adf_err_cnt u_err_cnt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step && fres.has_result),
        .ev          (fres.ev),
        .totals_next (totals_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= fres.has_result;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && fres.has_result)
        begin
            res_reg <= fres;
            tot_reg <= totals_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_res         = res_reg.ev;
    assign data_byte         = res_reg.data;
    assign position          = res_reg.pos;
    assign runt_total        = tot_reg.runt;
    assign abort_total       = tot_reg.abort;
    assign oversize_total    = tot_reg.oversize;
    assign parity_fail_total = tot_reg.parity;

endmodule

>>> tb/async_hdlc_deframer_parity_check_tb.sv
module async_hdlc_deframer_parity_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result item as the deframer reports it
    typedef struct packed {
        adf_pkg::event_t            ev;
        logic [adf_pkg::BYTE_W-1:0] data;
        logic [adf_pkg::LEN_W-1:0]  pos;
        adf_pkg::totals_t           tot;
    } deframe_out_t;

    // Directed rows: predicted, known to give nothing, or typed in by hand
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [adf_pkg::BYTE_W-1:0] line;
        adf_pkg::event_t            ev;
        logic [adf_pkg::BYTE_W-1:0] data;
        logic [adf_pkg::LEN_W-1:0]  pos;
    } line_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 70;
    localparam int FINAL_ROUNDS  = 12;
    localparam int HOLD_CYCLES   = 64;
    localparam int HOLD_AFTER    = 120;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [adf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [adf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [adf_pkg::BYTE_W-1:0]      rx_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [2:0]                      event_res;
    logic [adf_pkg::BYTE_W-1:0]      data_byte;
    logic [adf_pkg::LEN_W-1:0]       position;
    logic [adf_pkg::CNT_W-1:0]       runt_total;
    logic [adf_pkg::CNT_W-1:0]       abort_total;
    logic [adf_pkg::CNT_W-1:0]       oversize_total;
    logic [adf_pkg::CNT_W-1:0]       parity_fail_total;

    // Predictor copy of registers and frame state
    logic [adf_pkg::LEN_W-1:0]  min_len     = adf_pkg::MIN_LEN_RESET;
    logic [adf_pkg::LEN_W-1:0]  max_len     = adf_pkg::MAX_LEN_RESET;
    logic                       esc_pending = 1'b0;
    logic [adf_pkg::LEN_W-1:0]  frame_len   = '0;
    logic [adf_pkg::BYTE_W-1:0] xor_acc     = '0;
    adf_pkg::totals_t           tot         = '0;

    deframe_out_t expected_results[$];
    line_row_t    row_checks[$];

    int failures     = 0;
    int bytes_sent   = 0;
    int bytes_in     = 0;
    int results_seen = 0;
    int ev_tally[8]  = '{default: 0};
    int gap_pct      = 0;
    int stall_pct    = 0;

    logic [adf_pkg::CFG_DATA_W-1:0] min_words [NUM_PHASES-1] =
        '{16'h0001, 16'h0000, 16'hFE03, 16'h01FF, 16'h0005};
    logic [adf_pkg::CFG_DATA_W-1:0] max_words [NUM_PHASES-1] =
        '{16'h0001, 16'h0000, 16'h0208, 16'hFFFF, 16'h0010};

    // Directed walk at reset settings (min 4, max 511)
    line_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_NONE,    adf_pkg::FLAG_BYTE, adf_pkg::EV_DATA,   8'h00, 9'd0},  // empty frame
        '{ROW_TYPED,   8'h00,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   8'hFF,              adf_pkg::EV_DATA,   8'hFF, 9'd1},
        '{ROW_TYPED,   adf_pkg::FLAG_BYTE, adf_pkg::EV_RUNT,   8'h00, 9'd2},
        '{ROW_NONE,    adf_pkg::ESC_BYTE,  adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   8'h5E,              adf_pkg::EV_DATA,   8'h4E, 9'd0},
        '{ROW_NONE,    adf_pkg::ESC_BYTE,  adf_pkg::EV_DATA,   8'h00, 9'd0},  // double escape
        '{ROW_NONE,    adf_pkg::ESC_BYTE,  adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   8'h6D,              adf_pkg::EV_DATA,   8'h7D, 9'd1},
        '{ROW_NONE,    adf_pkg::ESC_BYTE,  adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   adf_pkg::FLAG_BYTE, adf_pkg::EV_ABORT,  8'h00, 9'd2},  // escaped flag
        '{ROW_NONE,    adf_pkg::ESC_BYTE,  adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   adf_pkg::FLAG_BYTE, adf_pkg::EV_ABORT,  8'h00, 9'd0},  // empty abort
        '{ROW_PREDICT, 8'h11,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h22,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h33,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h00,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   adf_pkg::FLAG_BYTE, adf_pkg::EV_GOOD,   8'h00, 9'd4},
        '{ROW_PREDICT, 8'h80,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h01,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h02,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_PREDICT, 8'h03,              adf_pkg::EV_DATA,   8'h00, 9'd0},
        '{ROW_TYPED,   adf_pkg::FLAG_BYTE, adf_pkg::EV_PARITY, 8'h00, 9'd4}
    };

    async_hdlc_deframer_parity_check uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .event_res         (event_res),
        .data_byte         (data_byte),
        .position          (position),
        .runt_total        (runt_total),
        .abort_total       (abort_total),
        .oversize_total    (oversize_total),
        .parity_fail_total (parity_fail_total)
    );

    always #4 clk = ~clk;

    function automatic logic [adf_pkg::CNT_W-1:0] sat_bump(
        input logic [adf_pkg::CNT_W-1:0] c);
        return (c == adf_pkg::CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Deframer step: updates frame state, returns 1 when a result comes out
    function automatic bit deframe_step(input logic [adf_pkg::BYTE_W-1:0] raw,
                                        output deframe_out_t r);
        logic [adf_pkg::BYTE_W-1:0] b;
        logic [adf_pkg::LEN_W-1:0]  held;
        logic [adf_pkg::LEN_W-1:0]  lim;
        b    = raw;
        held = frame_len;
        lim  = (max_len > adf_pkg::LIMIT_CAP) ? adf_pkg::LIMIT_CAP : max_len;
        r    = '0;
        r.pos = held;

        if (b == adf_pkg::FLAG_BYTE)
        begin
            if (esc_pending)
            begin
                tot.abort = sat_bump(tot.abort);
                r.ev = adf_pkg::EV_ABORT;
            end
            else if (held == '0)
            begin
                xor_acc = '0;
                return 1'b0;
            end
            else if (held < min_len)
            begin
                tot.runt = sat_bump(tot.runt);
                r.ev = adf_pkg::EV_RUNT;
            end
            else if (xor_acc != '0)
            begin
                tot.parity = sat_bump(tot.parity);
                r.ev = adf_pkg::EV_PARITY;
            end
            else
            begin
                r.ev = adf_pkg::EV_GOOD;
            end
            esc_pending = 1'b0;
            frame_len   = '0;
            xor_acc     = '0;
            r.tot = tot;
            return 1'b1;
        end

        if (b == adf_pkg::ESC_BYTE)
        begin
            esc_pending = 1'b1;
            return 1'b0;
        end

        if (esc_pending)
        begin
            b = b ^ adf_pkg::ESC_XOR;
            esc_pending = 1'b0;
        end

        // Byte beyond the limit is dropped and the frame restarts
        if (held >= lim)
        begin
            tot.oversize = sat_bump(tot.oversize);
            frame_len = '0;
            xor_acc   = '0;
            r.ev  = adf_pkg::EV_OVERSIZE;
            r.tot = tot;
            return 1'b1;
        end

        xor_acc   = xor_acc ^ b;
        frame_len = held + 1'b1;
        r.ev   = adf_pkg::EV_DATA;
        r.data = b;
        r.tot  = tot;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [adf_pkg::CNT_W-1:0] want_v,
                               input logic [adf_pkg::CNT_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            failures++;
        end
    endtask

    // Monitor: config and input transfers feed the predictor, results are checked
    always @(posedge clk)
    begin : monitor
        deframe_out_t want;
        line_row_t    row;
        bit           fires;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    adf_pkg::REG_MIN_FRAME_LEN: min_len = cfg_data[adf_pkg::LEN_W-1:0];
                    adf_pkg::REG_MAX_FRAME_LEN: max_len = cfg_data[adf_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                bytes_in++;
                fires = deframe_step(rx_byte, want);
                if (row_checks.size() != 0)
                begin
                    row = row_checks.pop_front();
                    if (row.kind == ROW_NONE)
                    begin
                        fires = 1'b0;
                    end
                    else if (row.kind == ROW_TYPED)
                    begin
                        fires     = 1'b1;
                        want.ev   = row.ev;
                        want.data = row.data;
                        want.pos  = row.pos;
                    end
                end
                if (fires)
                    expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                ev_tally[event_res]++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: event_res %0d position %0d", event_res,
                           position);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.ev, event_res);
                    check_field("data_byte", want.data, data_byte);
                    check_field("position", want.pos, position);
                    check_field("runt_total", want.tot.runt, runt_total);
                    check_field("abort_total", want.tot.abort, abort_total);
                    check_field("oversize_total", want.tot.oversize, oversize_total);
                    check_field("parity_fail_total", want.tot.parity, parity_fail_total);
                end
            end
        end
    end

    // Result side: random stalls plus one long hold-off so the pipeline backs up
    initial
    begin : result_sink
        bit held_once;
        held_once = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_once && results_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // One line byte transfer, with an optional idle burst before it
    task automatic send_byte(input logic [adf_pkg::BYTE_W-1:0] b);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        bytes_sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stuff a data byte; sometimes escape a byte that needs no escaping
    task automatic send_data(input logic [adf_pkg::BYTE_W-1:0] d);
        logic [adf_pkg::BYTE_W-1:0] flipped;
        flipped = d ^ adf_pkg::ESC_XOR;
        if (d == adf_pkg::FLAG_BYTE || d == adf_pkg::ESC_BYTE ||
            (flipped != adf_pkg::FLAG_BYTE && flipped != adf_pkg::ESC_BYTE &&
             $urandom_range(0, 15) == 0))
        begin
            send_byte(adf_pkg::ESC_BYTE);
            send_byte(flipped);
        end
        else
        begin
            send_byte(d);
        end
    endtask

    function automatic logic [adf_pkg::BYTE_W-1:0] line_byte_pick();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? adf_pkg::FLAG_BYTE : adf_pkg::ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(input int len, input bit zero_xor, input bit abort_end);
        logic [adf_pkg::BYTE_W-1:0] d;
        logic [adf_pkg::BYTE_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < len; i++)
        begin
            d   = (zero_xor && i == len - 1) ? acc : line_byte_pick();
            acc = acc ^ d;
            send_data(d);
        end
        if (abort_end)
            send_byte(adf_pkg::ESC_BYTE);
        send_byte(adf_pkg::FLAG_BYTE);
    endtask

    // Mostly short frames, with lengths around both limits when they are small
    function automatic int frame_len_pick();
        int lim;
        int r;
        lim = (max_len > adf_pkg::LIMIT_CAP) ? int'(adf_pkg::LIMIT_CAP) : int'(max_len);
        r   = $urandom_range(0, 99);
        if (r < 15 && min_len <= 40)
            return int'(min_len) + int'($urandom_range(0, 2)) - 1;
        if (r < 30 && lim <= 40)
            return lim + int'($urandom_range(0, 1));
        return $urandom_range(0, 10);
    endfunction

    task automatic random_frame();
        int pick;
        int len;
        pick      = $urandom_range(0, 99);
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 20;
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
        len       = frame_len_pick();
        if (pick < 6)
        begin
            // line noise, stray flags and escapes included
            repeat ($urandom_range(1, 6)) send_byte(line_byte_pick());
        end
        else
        begin
            send_frame(len, pick < 50, pick >= 88);
        end
    endtask

    // Wait for every expected result, then let the pipeline empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [adf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [adf_pkg::CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin : stimulus
        int phase_start;
        logic [adf_pkg::CFG_DATA_W-1:0] mn;
        logic [adf_pkg::CFG_DATA_W-1:0] mx;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row_checks.push_back(directed_rows[i]);
            send_byte(directed_rows[i].line);
        end

        // Random frames under a range of length settings
        for (int p = 0; p <= NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                if (p == NUM_PHASES)
                begin
                    mn = $urandom_range(1, 12);
                    mx = $urandom_range(int'(mn), 30);
                end
                else
                begin
                    mn = min_words[p-1];
                    mx = max_words[p-1];
                end
                write_reg(adf_pkg::REG_MIN_FRAME_LEN, mn);
                write_reg(8'(int'(adf_pkg::REG_MAX_FRAME_LEN) + $urandom_range(1, 254)),
                          16'($urandom));
                write_reg(adf_pkg::REG_MAX_FRAME_LEN, mx);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
        end

        // Final stretch at full rate: runt, parity, abort and oversize back to back
        write_reg({adf_pkg::CFG_INDEX_W{1'b1}}, {adf_pkg::CFG_DATA_W{1'b1}});
        write_reg(adf_pkg::REG_MIN_FRAME_LEN, 16'd2);
        write_reg(adf_pkg::REG_MAX_FRAME_LEN, 16'd2);
        gap_pct   = 0;
        stall_pct = 0;
        for (int n = 0; n < FINAL_ROUNDS; n++)
        begin
            send_byte(8'h01);
            send_byte(adf_pkg::FLAG_BYTE);
            send_byte(8'h01);
            send_byte(8'h02);
            send_byte(adf_pkg::FLAG_BYTE);
            send_byte(adf_pkg::ESC_BYTE);
            send_byte(adf_pkg::FLAG_BYTE);
            send_byte(8'h01);
            send_byte(8'h02);
            send_byte(8'h03);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Deframer run: %0d line bytes, %0d results (data %0d, good %0d, parity %0d,",
                 bytes_in, results_seen, ev_tally[adf_pkg::EV_DATA],
                 ev_tally[adf_pkg::EV_GOOD], ev_tally[adf_pkg::EV_PARITY]);
        $display("runt %0d, abort %0d, oversize %0d); limits 0 to 511, escapes, back-pressure",
                 ev_tally[adf_pkg::EV_RUNT], ev_tally[adf_pkg::EV_ABORT],
                 ev_tally[adf_pkg::EV_OVERSIZE]);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
